[hw/rtl/wmif_pkg.sv]
// Shared types and constants for the windowed majority input filter.
`default_nettype none

package wmif_pkg;

    localparam int CH_W   = 16;  // width of every per-channel vector on the ports
    localparam int EXP_W  = 3;   // width of one channel's window exponent
    localparam int FCH_W  = 4;   // width of the force channel select
    localparam int EXPS_W = CH_W * EXP_W;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 5;

    typedef enum logic [1:0] {
        REG_ACTIVE  = 2'd0,
        REG_DISABLE = 2'd1,
        REG_INVERT  = 2'd2,
        REG_WINDOW  = 2'd3
    } reg_idx_t;

    // Per-lane command for one transaction
    typedef struct packed {
        logic             sample;
        logic             force_hit;
        logic             force_value;
        logic             active;
        logic             decide_off;
        logic             invert;
        logic             pin;
        logic [EXP_W-1:0] exponent;
    } lane_cmd_t;

    // Per-lane state after the transaction
    typedef struct packed {
        logic filtered;
        logic ready;
    } lane_stat_t;

    typedef struct packed {
        logic [CH_W-1:0] filtered_values;
        logic [CH_W-1:0] ready_flags;
        logic            all_ready;
    } out_item_t;

endpackage

`default_nettype wire

[hw/rtl/wmif_if.sv]
// Input and output channel interfaces of the windowed majority input filter.
`default_nettype none

interface wmif_in_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [wmif_pkg::CH_W-1:0]     pin_samples;
    logic [wmif_pkg::FCH_W-1:0]    force_channel;
    logic                          force_value;

    modport source (output valid, output req_type, output pin_samples,
                    output force_channel, output force_value, input ready);
    modport sink   (input valid, input req_type, input pin_samples,
                    input force_channel, input force_value, output ready);
endinterface

interface wmif_out_if;
    logic                      valid;
    logic                      ready;
    logic [wmif_pkg::CH_W-1:0] filtered_values;
    logic [wmif_pkg::CH_W-1:0] ready_flags;
    logic                      all_ready;

    modport source (output valid, output filtered_values, output ready_flags,
                    output all_ready, input ready);
    modport sink   (input valid, input filtered_values, input ready_flags,
                    input all_ready, output ready);
endinterface

`default_nettype wire

[hw/rtl/wmif_lane.sv]
// One channel lane: window counters, majority decision, filtered and ready bits.
`default_nettype none

module wmif_lane #(
    parameter int MAX_EXPONENT = 7
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       take,
    input  wire wmif_pkg::lane_cmd_t  cmd,
    output wmif_pkg::lane_stat_t      stat
);

    // Counts reach at most the window length 2^MAX_EXPONENT
    localparam int CNT_W = MAX_EXPONENT + 1;

    logic [CNT_W-1:0] sample_cnt_reg, sample_cnt_next;
    logic [CNT_W-1:0] ones_cnt_reg, ones_cnt_next;
    logic             filt_reg, filt_next;
    logic             rdy_reg, rdy_next;

    always_comb
    begin
        logic [wmif_pkg::EXP_W-1:0] exp_sat;
        logic [CNT_W-1:0]           win;
        logic [CNT_W-1:0]           quarter;
        logic [CNT_W-1:0]           s_inc;
        logic [CNT_W-1:0]           o_inc;
        logic                       level;

        sample_cnt_next = sample_cnt_reg;
        ones_cnt_next   = ones_cnt_reg;
        filt_next       = filt_reg;
        rdy_next        = rdy_reg;

        exp_sat = cmd.exponent;
        if (cmd.exponent > wmif_pkg::EXP_W'(MAX_EXPONENT))
        begin
            exp_sat = wmif_pkg::EXP_W'(MAX_EXPONENT);
        end
        win     = CNT_W'(1) << exp_sat;
        quarter = win >> 2;
        level   = cmd.pin ^ cmd.invert;
        s_inc   = sample_cnt_reg + CNT_W'(1);
        o_inc   = ones_cnt_reg + CNT_W'(level);

        if (cmd.force_hit)
        begin
            filt_next = cmd.force_value;
        end
        else if (cmd.sample && cmd.active)
        begin
            sample_cnt_next = s_inc;
            ones_cnt_next   = o_inc;
            if (s_inc >= win)
            begin
                if (o_inc >= win - quarter)
                begin
                    if (!cmd.decide_off)
                    begin
                        filt_next = 1'b1;
                    end
                end
                else if (o_inc <= quarter)
                begin
                    if (!cmd.decide_off)
                    begin
                        filt_next = 1'b0;
                    end
                end
                rdy_next        = 1'b1;
                sample_cnt_next = '0;
                ones_cnt_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_cnt_reg <= '0;
            ones_cnt_reg   <= '0;
            filt_reg       <= 1'b0;
            rdy_reg        <= 1'b0;
        end
        else if (take)
        begin
            sample_cnt_reg <= sample_cnt_next;
            ones_cnt_reg   <= ones_cnt_next;
            filt_reg       <= filt_next;
            rdy_reg        <= rdy_next;
        end
    end

    assign stat.filtered = filt_next;
    assign stat.ready    = rdy_next;

endmodule

`default_nettype wire

[hw/rtl/wmif_merge.sv]
// Merge of lane results into one result transaction, with a two-entry output buffer.
`default_nettype none

module wmif_merge #(
    parameter int CHANNELS = 16
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       take,
    input  wire [CHANNELS-1:0]        act,
    input  wire wmif_pkg::lane_stat_t stat [CHANNELS],
    output logic                      in_ready,
    wmif_out_if.source                out_ch
);

    logic [CHANNELS-1:0]  filt_vec;
    logic [CHANNELS-1:0]  rdy_vec;
    wmif_pkg::out_item_t  item;
    wmif_pkg::out_item_t  main_reg;
    wmif_pkg::out_item_t  skid_reg;
    logic                 main_valid_reg;
    logic                 skid_valid_reg;
    logic                 pop;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            filt_vec[c] = stat[c].filtered;
            rdy_vec[c]  = stat[c].ready;
        end
    end

    assign item.filtered_values = wmif_pkg::CH_W'(filt_vec);
    assign item.ready_flags     = wmif_pkg::CH_W'(rdy_vec);
    assign item.all_ready       = ((act & ~rdy_vec) == '0);

    assign pop      = main_valid_reg && out_ch.ready;
    assign in_ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (!take)
            begin
                main_valid_reg <= 1'b0;
            end
        end
        else if (take)
        begin
            if (!main_valid_reg)
            begin
                main_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Payload: advance skid into main on pop, else load the new transaction
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (take)
            begin
                main_reg <= item;
            end
        end
        else if (take)
        begin
            if (!main_valid_reg)
            begin
                main_reg <= item;
            end
            else
            begin
                skid_reg <= item;
            end
        end
    end

    assign out_ch.valid           = main_valid_reg;
    assign out_ch.filtered_values = main_reg.filtered_values;
    assign out_ch.ready_flags     = main_reg.ready_flags;
    assign out_ch.all_ready       = main_reg.all_ready;

endmodule

`default_nettype wire

[hw/rtl/windowed_majority_input_filter.sv]
// Top level of the windowed majority input filter: register file, lanes and merge.
`default_nettype none

// Windowed majority input filter. Every channel has its own lane that counts
// samples and ones over a window of 2^e ticks and sets, clears or holds its
// filtered bit at the end of the window; all lanes update in parallel in the
// cycle a transaction is accepted, so one transaction (sample tick or force)
// is taken every clock while the output buffer has room. Results are held
// in a two-entry output buffer: the input keeps accepting while one result
// waits, and stalls only when both entries are full. The user must write
// the configuration over the APB port at byte address 8*i (active, disable,
// invert, window exponents) only while the block is idle; it is not enforced.
module windowed_majority_input_filter #(
    parameter int CHANNELS     = 16,
    parameter int MAX_EXPONENT = 7
) (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [wmif_pkg::ADDR_W-1:0]      paddr,
    input  wire [wmif_pkg::DATA_W-1:0]      pwdata,
    output logic [wmif_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    wmif_in_if.sink                         in_ch,
    wmif_out_if.source                      out_ch
);

    logic [wmif_pkg::CH_W-1:0]   active_reg;
    logic [wmif_pkg::CH_W-1:0]   disable_reg;
    logic [wmif_pkg::CH_W-1:0]   invert_reg;
    logic [wmif_pkg::EXPS_W-1:0] window_reg;
    wmif_pkg::reg_idx_t          reg_idx;
    logic                        cfg_wr;
    logic                        take;
    logic                        in_ready;
    wmif_pkg::lane_cmd_t         cmd  [CHANNELS];
    wmif_pkg::lane_stat_t        stat [CHANNELS];

    assign pready  = 1'b1;
    assign reg_idx = wmif_pkg::reg_idx_t'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= '0;
            disable_reg <= '0;
            invert_reg  <= '0;
            window_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                wmif_pkg::REG_ACTIVE:  active_reg  <= pwdata[wmif_pkg::CH_W-1:0];
                wmif_pkg::REG_DISABLE: disable_reg <= pwdata[wmif_pkg::CH_W-1:0];
                wmif_pkg::REG_INVERT:  invert_reg  <= pwdata[wmif_pkg::CH_W-1:0];
                wmif_pkg::REG_WINDOW:  window_reg  <= pwdata[wmif_pkg::EXPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            wmif_pkg::REG_ACTIVE:  prdata = wmif_pkg::DATA_W'(active_reg);
            wmif_pkg::REG_DISABLE: prdata = wmif_pkg::DATA_W'(disable_reg);
            wmif_pkg::REG_INVERT:  prdata = wmif_pkg::DATA_W'(invert_reg);
            wmif_pkg::REG_WINDOW:  prdata = wmif_pkg::DATA_W'(window_reg);
            default:               prdata = '0;
        endcase
    end

    assign take        = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        assign cmd[c].sample      = !in_ch.req_type;
        assign cmd[c].force_hit   = in_ch.req_type &&
                                    (in_ch.force_channel == wmif_pkg::FCH_W'(c));
        assign cmd[c].force_value = in_ch.force_value;
        assign cmd[c].active      = active_reg[c];
        assign cmd[c].decide_off  = disable_reg[c];
        assign cmd[c].invert      = invert_reg[c];
        assign cmd[c].pin         = in_ch.pin_samples[c];
        assign cmd[c].exponent    = window_reg[c*wmif_pkg::EXP_W +: wmif_pkg::EXP_W];

        wmif_lane #(
            .MAX_EXPONENT (MAX_EXPONENT)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .take  (take),
            .cmd   (cmd[c]),
            .stat  (stat[c])
        );
    end

    wmif_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .act      (active_reg[CHANNELS-1:0]),
        .stat     (stat),
        .in_ready (in_ready),
        .out_ch   (out_ch)
    );

`ifndef ASSERT_OFF
    // A full buffer always has a result on offer
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> out_ch.valid)
        else $error("input stalled with no result on offer");

    // A transaction taken while the head result stalls fills the second entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && out_ch.valid && !out_ch.ready) |=> !in_ch.ready)
        else $error("output buffer did not fill its second entry");

    // Channels beyond the configured count never report bits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |->
            ((out_ch.filtered_values >> CHANNELS) == '0) &&
            ((out_ch.ready_flags >> CHANNELS) == '0))
        else $error("bits set above the channel count");
`endif

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the windowed majority input filter.
`timescale 1ns / 1ps

module tb;

    localparam bit REQ_SAMPLE  = 1'b0;
    localparam bit REQ_FORCE   = 1'b1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 13;
    localparam int PHASE_ITEMS = 50;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [wmif_pkg::ADDR_W-1:0] paddr;
    logic [wmif_pkg::DATA_W-1:0] pwdata;
    logic [wmif_pkg::DATA_W-1:0] prdata;
    logic pready;

    wmif_in_if  in_ch ();
    wmif_out_if out_ch ();

    windowed_majority_input_filter DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Shadow of the register file
    logic [wmif_pkg::CH_W-1:0]   cfg_active;
    logic [wmif_pkg::CH_W-1:0]   cfg_disable;
    logic [wmif_pkg::CH_W-1:0]   cfg_invert;
    logic [wmif_pkg::EXPS_W-1:0] cfg_window;

    // Shadow of the per-channel filter state
    logic [wmif_pkg::CH_W-1:0] pred_filtered;
    logic [wmif_pkg::CH_W-1:0] pred_ready;
    logic [6:0]                sample_cnt [wmif_pkg::CH_W];
    logic [7:0]                ones_cnt   [wmif_pkg::CH_W];

    wmif_pkg::out_item_t pending_status [$];
    int                  mismatches;
    int                  cycles;
    int                  gap_max;
    int                  stall_max;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("windowed_majority_input_filter: mismatch");
            $finish;
        end
    end

    // Advance the shadow filter by one transaction and return the status it reports.
    function automatic wmif_pkg::out_item_t advance_filter(
        input bit req, input logic [wmif_pkg::CH_W-1:0] pins,
        input logic [wmif_pkg::FCH_W-1:0] fch, input bit fval);
        wmif_pkg::out_item_t status;
        logic [7:0]          nsamp;
        logic [7:0]          nones;
        int                  win;
        int                  quarter;
        if (req == REQ_FORCE)
        begin
            pred_filtered[fch] = fval;
        end
        else
        begin
            for (int c = 0; c < wmif_pkg::CH_W; c++)
            begin
                if (!cfg_active[c])
                    continue;
                nones = ones_cnt[c] + ((pins[c] ^ cfg_invert[c]) ? 8'd1 : 8'd0);
                nsamp = {1'b0, sample_cnt[c]} + 8'd1;
                win   = 1 << cfg_window[wmif_pkg::EXP_W*c +: wmif_pkg::EXP_W];
                // A count already past a shrunken window decides at once
                if (nsamp >= win)
                begin
                    quarter = win / 4;
                    if (nones >= win - quarter)
                    begin
                        if (!cfg_disable[c])
                            pred_filtered[c] = 1'b1;
                    end
                    else if (nones <= quarter)
                    begin
                        if (!cfg_disable[c])
                            pred_filtered[c] = 1'b0;
                    end
                    pred_ready[c] = 1'b1;
                    nsamp = 8'd0;
                    nones = 8'd0;
                end
                sample_cnt[c] = nsamp[6:0];
                ones_cnt[c]   = nones;
            end
        end
        status.filtered_values = pred_filtered;
        status.ready_flags     = pred_ready;
        status.all_ready       = ((cfg_active & ~pred_ready) == '0);
        return status;
    endfunction

    task automatic write_reg(input wmif_pkg::reg_idx_t idx,
                             input logic [wmif_pkg::DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            wmif_pkg::REG_ACTIVE:  cfg_active  = value[wmif_pkg::CH_W-1:0];
            wmif_pkg::REG_DISABLE: cfg_disable = value[wmif_pkg::CH_W-1:0];
            wmif_pkg::REG_INVERT:  cfg_invert  = value[wmif_pkg::CH_W-1:0];
            wmif_pkg::REG_WINDOW:  cfg_window  = value[wmif_pkg::EXPS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_item(input bit req, input logic [wmif_pkg::CH_W-1:0] pins,
                             input logic [wmif_pkg::FCH_W-1:0] fch, input bit fval);
        int gap;
        gap = $urandom_range(gap_max, 0);
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.req_type      <= req;
        in_ch.pin_samples   <= pins;
        in_ch.force_channel <= fch;
        in_ch.force_value   <= fval;
        do @(posedge clk); while (!in_ch.ready);
        pending_status.push_back(advance_filter(req, pins, fch, fval));
    endtask

    // Drop valid and hold until every status has come back.
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_force_when_idle();
        gap_max   = 11;
        stall_max = 11;
        send_item(REQ_SAMPLE, 16'hFFFF, 4'd0, 1'b0);
        send_item(REQ_FORCE, 16'h0000, 4'd0, 1'b1);
        send_item(REQ_FORCE, 16'hFFFF, 4'd15, 1'b1);
        send_item(REQ_FORCE, 16'h0000, 4'd15, 1'b0);
        send_item(REQ_FORCE, 16'h0000, 4'd7, 1'b1);
        send_item(REQ_SAMPLE, 16'h0000, 4'd15, 1'b1);
        settle();
    endtask

    task automatic test_unit_window();
        write_reg(wmif_pkg::REG_ACTIVE, 64'hFFFF);
        write_reg(wmif_pkg::REG_DISABLE, 64'h0);
        write_reg(wmif_pkg::REG_INVERT, 64'h0);
        write_reg(wmif_pkg::REG_WINDOW, 64'h0);
        send_item(REQ_SAMPLE, 16'hFFFF, 4'd0, 1'b0);
        send_item(REQ_SAMPLE, 16'h0000, 4'd0, 1'b0);
        settle();
        write_reg(wmif_pkg::REG_INVERT, 64'hAAAA);
        send_item(REQ_SAMPLE, 16'h0000, 4'd0, 1'b0);
        settle();
        write_reg(wmif_pkg::REG_DISABLE, 64'h00FF);
        write_reg(wmif_pkg::REG_INVERT, 64'h0);
        send_item(REQ_SAMPLE, 16'hFFFF, 4'd0, 1'b0);
        // force still lands on a disabled channel
        send_item(REQ_FORCE, 16'h0000, 4'd3, 1'b1);
        settle();
    endtask

    task automatic test_hold_band();
        write_reg(wmif_pkg::REG_DISABLE, 64'h0);
        write_reg(wmif_pkg::REG_ACTIVE, 64'h7FFF);
        write_reg(wmif_pkg::REG_WINDOW, {16'h0, {16{3'd2}}});
        send_item(REQ_SAMPLE, 16'hFFFF, 4'd0, 1'b0);
        send_item(REQ_SAMPLE, 16'h00FF, 4'd0, 1'b0);
        send_item(REQ_SAMPLE, 16'h0F0F, 4'd0, 1'b0);
        send_item(REQ_SAMPLE, 16'h3333, 4'd0, 1'b0);
        settle();
    endtask

    task automatic test_window_shrink();
        write_reg(wmif_pkg::REG_ACTIVE, 64'hFFFF);
        write_reg(wmif_pkg::REG_WINDOW, {16'h0, {16{3'd3}}});
        repeat (5) send_item(REQ_SAMPLE, 16'hF0F0, 4'd0, 1'b0);
        settle();
        write_reg(wmif_pkg::REG_WINDOW, {16'h0, {16{3'd1}}});
        send_item(REQ_SAMPLE, 16'h0000, 4'd0, 1'b0);
        settle();
        write_reg(wmif_pkg::REG_WINDOW, {wmif_pkg::DATA_W{1'b1}});
        send_item(REQ_SAMPLE, 16'hFFFF, 4'd0, 1'b0);
        settle();
    endtask

    task automatic test_random_traffic();
        logic [wmif_pkg::CH_W-1:0]   pins;
        logic [wmif_pkg::CH_W-1:0]   base;
        logic [wmif_pkg::EXPS_W-1:0] exps;
        int                          bias;
        int                          top_exp;
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case ($urandom_range(3, 0))
                0: write_reg(wmif_pkg::REG_ACTIVE, 64'h0);
                1: write_reg(wmif_pkg::REG_ACTIVE, 64'hFFFF);
                default: write_reg(wmif_pkg::REG_ACTIVE, {48'h0, 16'($urandom)});
            endcase
            write_reg(wmif_pkg::REG_DISABLE,
                      ($urandom_range(2, 0) == 0) ? {48'h0, 16'($urandom)} : 64'h0);
            write_reg(wmif_pkg::REG_INVERT,
                      ($urandom_range(1, 0) == 0) ? {48'h0, 16'($urandom)} : 64'h0);
            // mostly short windows so decisions come often
            top_exp = ($urandom_range(3, 0) == 0) ? 7 : 3;
            for (int c = 0; c < wmif_pkg::CH_W; c++)
                exps[wmif_pkg::EXP_W*c +: wmif_pkg::EXP_W] =
                    wmif_pkg::EXP_W'($urandom_range(top_exp, 0));
            if ($urandom_range(5, 0) != 0)
                write_reg(wmif_pkg::REG_WINDOW, {16'h0, exps});
            gap_max   = ($urandom_range(2, 0) == 0) ? 0 : 11;
            stall_max = ($urandom_range(2, 0) == 0) ? 0 : 11;
            bias = $urandom_range(3, 0);
            base = 16'($urandom);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                case (bias)
                    0: pins = 16'($urandom);
                    1: pins = 16'($urandom) | 16'($urandom);
                    2: pins = 16'($urandom) & 16'($urandom);
                    default: pins = base ^ (16'($urandom) & 16'($urandom) & 16'($urandom));
                endcase
                if ($urandom_range(9, 0) == 0)
                    send_item(REQ_FORCE, pins, 4'($urandom_range(15, 0)),
                              1'($urandom_range(1, 0)));
                else
                    send_item(REQ_SAMPLE, pins, 4'($urandom_range(15, 0)),
                              1'($urandom_range(1, 0)));
            end
        end
        settle();
    endtask

    // Receiver: stall a random number of cycles before each transaction.
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        forever
        begin
            stall = $urandom_range(stall_max, 0);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        wmif_pkg::out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_status.size() == 0)
            begin
                $display("%0t: unexpected transaction, got filtered %h ready %h all %b",
                         $time, out_ch.filtered_values, out_ch.ready_flags, out_ch.all_ready);
                mismatches++;
            end
            else
            begin
                want = pending_status.pop_front();
                if (out_ch.filtered_values !== want.filtered_values)
                begin
                    $display("%0t: filtered_values expected %h got %h", $time,
                             want.filtered_values, out_ch.filtered_values);
                    mismatches++;
                end
                if (out_ch.ready_flags !== want.ready_flags)
                begin
                    $display("%0t: ready_flags expected %h got %h", $time,
                             want.ready_flags, out_ch.ready_flags);
                    mismatches++;
                end
                if (out_ch.all_ready !== want.all_ready)
                begin
                    $display("%0t: all_ready expected %b got %b", $time,
                             want.all_ready, out_ch.all_ready);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_ch.valid         = 1'b0;
        in_ch.req_type      = REQ_SAMPLE;
        in_ch.pin_samples   = '0;
        in_ch.force_channel = '0;
        in_ch.force_value   = 1'b0;
        mismatches          = 0;
        cycles              = 0;
        gap_max             = 11;
        stall_max           = 11;
        cfg_active          = '0;
        cfg_disable         = '0;
        cfg_invert          = '0;
        cfg_window          = '0;
        pred_filtered       = '0;
        pred_ready          = '0;
        for (int c = 0; c < wmif_pkg::CH_W; c++)
        begin
            sample_cnt[c] = '0;
            ones_cnt[c]   = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_force_when_idle();
        test_unit_window();
        test_hold_band();
        test_window_shrink();
        test_random_traffic();

        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("windowed_majority_input_filter: match");
        else
            $display("windowed_majority_input_filter: mismatch");
        $finish;
    end

endmodule
